[hw/rtl/gfau_pkg.sv]
// gfau_pkg: types, action codes and field helpers for the GF(2^8) arithmetic unit
// no dependencies; used by gfau_mult and gf256_arithmetic_unit
package gfau_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] action_t;

  localparam action_t ACT_ADD   = 2'd0;
  localparam action_t ACT_XTIME = 2'd1;
  localparam action_t ACT_MUL   = 2'd2;
  localparam action_t ACT_INV   = 2'd3;

  // low byte of x^8 + x^4 + x^3 + x + 1
  localparam byte_t GF_POLY = 8'h1b;
  localparam byte_t GF_ONE  = 8'h01;
  // a^254 = a^2 * a^4 * ... * a^128
  localparam int INV_SQUARINGS = 7;

  function automatic byte_t gf_xtime(input byte_t v);
    byte_t shifted;
    shifted = {v[6:0], 1'b0};
    if (v[7]) begin
      shifted = shifted ^ GF_POLY;
    end
    return shifted;
  endfunction

  // squaring is linear: horner over x^2, msb first
  function automatic byte_t gf_square(input byte_t v);
    byte_t acc;
    acc = '0;
    for (int i = 7; i >= 0; i--) begin
      acc = gf_xtime(gf_xtime(acc));
      acc[0] = acc[0] ^ v[i];
    end
    return acc;
  endfunction

endpackage

[hw/rtl/gfau_mult.sv]
// gfau_mult: combinational GF(2^8) multiplier, shift-and-add msb first
// depends on gfau_pkg
module gfau_mult (
  input  gfau_pkg::byte_t op_a,
  input  gfau_pkg::byte_t op_b,
  output gfau_pkg::byte_t prod
);

  gfau_pkg::byte_t acc;

  always_comb begin
    acc = '0;
    for (int i = 7; i >= 0; i--) begin
      acc = gfau_pkg::gf_xtime(acc);
      if (op_a[i]) begin
        acc = acc ^ op_b;
      end
    end
  end

  assign prod = acc;

endmodule

[hw/rtl/gf256_arithmetic_unit.sv]
// gf256_arithmetic_unit: top level of the GF(2^8) add / xtime / multiply / inverse unit
// depends on gfau_pkg and gfau_mult
//
// Byte arithmetic in GF(2^8) with the AES polynomial. A request is taken on
// every cycle with start high and busy low; busy is high only while reset is
// held, so one request per clock is sustained. Every request yields exactly one
// result, shown on out_result for a single cycle with out_valid high, after the
// request has passed all four register stages, in request order. The result side cannot
// stall and the pipeline never holds anything back, so nothing is buffered.
// The pipeline has four register stages: power generation (a^2..a^128),
// then a three-level tree of GF multipliers that forms a^254 for the inverse;
// the multiply action rides the first multiplier of that tree and passes the
// later levels through a multiply by one. Inverse of zero gives zero.
module gf256_arithmetic_unit (
  input  logic                clk,
  input  logic                rst_n,
  // request side
  input  logic                start,
  output logic                busy,
  input  gfau_pkg::action_t   in_action,
  input  gfau_pkg::byte_t     in_operand_a,
  input  gfau_pkg::byte_t     in_operand_b,
  // result side
  output logic                out_valid,
  output gfau_pkg::byte_t     out_result
);

  localparam int NPOW = gfau_pkg::INV_SQUARINGS;

  logic req_acc;

  // busy only while reset holds the pipeline
  assign busy    = !rst_n;
  assign req_acc = start && !busy;

  // stage 1: squaring chain and the cheap actions
  logic              v1_r;
  gfau_pkg::action_t act1_r;
  gfau_pkg::byte_t   a1_r, b1_r, simp1_r;
  gfau_pkg::byte_t   pow1_r [NPOW];
  gfau_pkg::byte_t   pow_nxt [NPOW];
  gfau_pkg::byte_t   simp_nxt;

  always_comb begin
    pow_nxt[0] = gfau_pkg::gf_square(in_operand_a);
    for (int i = 1; i < NPOW; i++) begin
      pow_nxt[i] = gfau_pkg::gf_square(pow_nxt[i-1]);
    end
    if (in_action == gfau_pkg::ACT_ADD) begin
      simp_nxt = in_operand_a ^ in_operand_b;
    end else begin
      simp_nxt = gfau_pkg::gf_xtime(in_operand_a);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= req_acc;
    end
    act1_r  <= in_action;
    a1_r    <= in_operand_a;
    b1_r    <= in_operand_b;
    simp1_r <= simp_nxt;
    pow1_r  <= pow_nxt;
  end

  // stage 2: first multiplier level; lane 0 carries a*b for multiply requests
  logic              v2_r;
  gfau_pkg::action_t act2_r;
  gfau_pkg::byte_t   simp2_r, p128_2_r;
  gfau_pkg::byte_t   m0_r, m1_r, m2_r;
  gfau_pkg::byte_t   l0_a, l0_b, m0_nxt, m1_nxt, m2_nxt;
  logic              is_mul1;

  assign is_mul1 = (act1_r == gfau_pkg::ACT_MUL);
  assign l0_a    = is_mul1 ? a1_r : pow1_r[0];
  assign l0_b    = is_mul1 ? b1_r : pow1_r[1];

  gfau_mult u_mult_l1_0 (.op_a(l0_a),      .op_b(l0_b),      .prod(m0_nxt));
  gfau_mult u_mult_l1_1 (.op_a(pow1_r[2]), .op_b(pow1_r[3]), .prod(m1_nxt));
  gfau_mult u_mult_l1_2 (.op_a(pow1_r[4]), .op_b(pow1_r[5]), .prod(m2_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    act2_r   <= act1_r;
    simp2_r  <= simp1_r;
    p128_2_r <= pow1_r[NPOW-1];
    m0_r     <= m0_nxt;
    m1_r     <= m1_nxt;
    m2_r     <= m2_nxt;
  end

  // stage 3: second level; multiply requests pass through times one
  logic              v3_r;
  gfau_pkg::action_t act3_r;
  gfau_pkg::byte_t   simp3_r, n0_r, n1_r;
  gfau_pkg::byte_t   l2_b, n0_nxt, n1_nxt;
  logic              is_mul2;

  assign is_mul2 = (act2_r == gfau_pkg::ACT_MUL);
  assign l2_b    = is_mul2 ? gfau_pkg::GF_ONE : m1_r;

  gfau_mult u_mult_l2_0 (.op_a(m0_r), .op_b(l2_b),     .prod(n0_nxt));
  gfau_mult u_mult_l2_1 (.op_a(m2_r), .op_b(p128_2_r), .prod(n1_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    act3_r  <= act2_r;
    simp3_r <= simp2_r;
    n0_r    <= n0_nxt;
    n1_r    <= n1_nxt;
  end

  // stage 4: last level and result select into the output register
  logic            v4_r;
  gfau_pkg::byte_t res4_r;
  gfau_pkg::byte_t l3_b, fin_prod, res_nxt;

  assign l3_b = (act3_r == gfau_pkg::ACT_MUL) ? gfau_pkg::GF_ONE : n1_r;

  gfau_mult u_mult_l3 (.op_a(n0_r), .op_b(l3_b), .prod(fin_prod));

  always_comb begin
    case (act3_r)
      gfau_pkg::ACT_ADD:   res_nxt = simp3_r;
      gfau_pkg::ACT_XTIME: res_nxt = simp3_r;
      gfau_pkg::ACT_MUL:   res_nxt = fin_prod;
      gfau_pkg::ACT_INV:   res_nxt = fin_prod;
      default:             res_nxt = fin_prod;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    res4_r <= res_nxt;
  end

  assign out_valid  = v4_r;
  assign out_result = res4_r;

  // every accepted request comes out as a result strobe
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    req_acc |-> ##4 out_valid)
    else $error("request did not produce a result after four cycles");

  a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(req_acc, 4))
    else $error("result strobe without a matching request");

  // inverse of zero is zero
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (req_acc && in_action == gfau_pkg::ACT_INV && in_operand_a == 8'h00)
      |-> ##4 (out_result == 8'h00))
    else $error("inverse of zero is not zero");

  // multiply by one returns the other operand through the tree bypass
  a_mul_one: assert property (@(posedge clk) disable iff (!rst_n)
    (req_acc && in_action == gfau_pkg::ACT_MUL && in_operand_a == gfau_pkg::GF_ONE)
      |-> ##4 (out_result == $past(in_operand_b, 4)))
    else $error("multiply by one lost the second operand");

endmodule
